// ===== hw/rtl/epse_pkg.sv =====
// shared types, constants and rounding helpers for the even polynomial surface evaluator
package epse_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int ACC_W      = 54;
    localparam int PROD_W     = 65;
    localparam int RND_W      = PROD_W - FRAC_W;
    localparam int NUM_COEFFS = 4;
    localparam int ADDR_W     = 5;

    localparam logic [DATA_W-1:0]        INV_APERTURE_RESET = 32'h0001_0000;
    localparam logic signed [DATA_W:0]   ONE_Q16            = 33'sh0_0001_0000;
    localparam logic signed [DATA_W-1:0] SAT_MAX            = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] SAT_MIN            = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0] ROUND_POS          = 65'sh8000;
    localparam logic signed [PROD_W-1:0] ROUND_NEG          = 65'sh7FFF;

    typedef enum logic [2:0] {
        REG_BASE_HEIGHT      = 3'd0,
        REG_INVERSE_APERTURE = 3'd1,
        REG_TERM_COUNT       = 3'd2,
        REG_COEFF_ONE        = 3'd3,
        REG_COEFF_TWO        = 3'd4,
        REG_COEFF_THREE      = 3'd5,
        REG_COEFF_FOUR       = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [DATA_W-1:0]                   base_height;
        logic [DATA_W-1:0]                   inverse_aperture;
        logic [2:0]                          term_count;
        logic [NUM_COEFFS-1:0][DATA_W-1:0]   coeff;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] u;
        logic signed [DATA_W-1:0] p;
        logic signed [ACC_W-1:0]  h_acc;
        logic signed [ACC_W-1:0]  s_acc;
        logic signed [ACC_W-1:0]  h_term;
        logic signed [ACC_W-1:0]  s_term;
        logic                     flag;
    } pipe_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              clip;
    } sat_t;

    // rescale by 2^16, half away from zero
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] sum;
        sum = v + (v[PROD_W-1] ? ROUND_NEG : ROUND_POS);
        return sum[PROD_W-1:FRAC_W];
    endfunction

    function automatic sat_t sat32(input logic signed [RND_W-1:0] v);
        sat_t res;
        res.clip  = (v[RND_W-1:DATA_W-1] != {(RND_W-DATA_W+1){v[DATA_W-1]}});
        res.value = res.clip ? (v[RND_W-1] ? SAT_MIN : SAT_MAX) : v[DATA_W-1:0];
        return res;
    endfunction

endpackage

// ===== hw/rtl/epse_regs.sv =====
// apb register file for height, aperture, term count and coefficients
module epse_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [epse_pkg::ADDR_W-1:0]       paddr,
    input  logic [epse_pkg::DATA_W-1:0]       pwdata,
    output logic [epse_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    output epse_pkg::cfg_t                    cfg
);

    epse_pkg::cfg_t       cfg_reg;
    epse_pkg::reg_index_t index;
    logic                 wr_en;

    assign index  = epse_pkg::reg_index_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_height      <= '0;
            cfg_reg.inverse_aperture <= epse_pkg::INV_APERTURE_RESET;
            cfg_reg.term_count       <= '0;
            cfg_reg.coeff            <= '0;
        end else if (wr_en) begin
            case (index)
                epse_pkg::REG_BASE_HEIGHT:      cfg_reg.base_height      <= pwdata;
                epse_pkg::REG_INVERSE_APERTURE: cfg_reg.inverse_aperture <= pwdata;
                epse_pkg::REG_TERM_COUNT:       cfg_reg.term_count       <= pwdata[2:0];
                epse_pkg::REG_COEFF_ONE:        cfg_reg.coeff[0]         <= pwdata;
                epse_pkg::REG_COEFF_TWO:        cfg_reg.coeff[1]         <= pwdata;
                epse_pkg::REG_COEFF_THREE:      cfg_reg.coeff[2]         <= pwdata;
                epse_pkg::REG_COEFF_FOUR:       cfg_reg.coeff[3]         <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (index)
            epse_pkg::REG_BASE_HEIGHT:      prdata = cfg_reg.base_height;
            epse_pkg::REG_INVERSE_APERTURE: prdata = cfg_reg.inverse_aperture;
            epse_pkg::REG_TERM_COUNT:       prdata = {29'd0, cfg_reg.term_count};
            epse_pkg::REG_COEFF_ONE:        prdata = cfg_reg.coeff[0];
            epse_pkg::REG_COEFF_TWO:        prdata = cfg_reg.coeff[1];
            epse_pkg::REG_COEFF_THREE:      prdata = cfg_reg.coeff[2];
            epse_pkg::REG_COEFF_FOUR:       prdata = cfg_reg.coeff[3];
            default:                        prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/epse_front.sv =====
// front stages: magnitude of x, scale by 1/A, round and clip to u
module epse_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  epse_pkg::cfg_t                cfg,
    input  logic [2:0]                    term_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [epse_pkg::DATA_W-1:0]   in_position,
    output logic                          out_valid,
    input  logic                          out_ready,
    output epse_pkg::pipe_t               out_pipe
);

    logic [2:0]  v_reg;
    logic [2:0]  ld;

    logic [31:0] mag_reg;
    logic        neg0_reg;
    logic [63:0] prod_reg;
    logic        neg1_reg;

    logic [63:0] rsum;
    logic [47:0] rmag;
    logic        clip_u;
    logic [31:0] u_next;
    epse_pkg::pipe_t pipe_reg;

    always_comb begin
        ld[2] = !v_reg[2] || out_ready;
        ld[1] = !v_reg[1] || ld[2];
        ld[0] = !v_reg[0] || ld[1];
    end

    assign in_ready  = ld[0];
    assign out_valid = v_reg[2];
    assign out_pipe  = pipe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= in_valid;
            if (ld[1]) v_reg[1] <= v_reg[0];
            if (ld[2]) v_reg[2] <= v_reg[1];
        end
    end

    // round half away from zero on the magnitude, then clip with the sign
    always_comb begin
        rsum = prod_reg + 64'h8000;
        rmag = rsum[63:16];
        if (neg1_reg) begin
            clip_u = (rmag[47:32] != '0) || (rmag[31] && (rmag[30:0] != '0));
            u_next = clip_u ? epse_pkg::SAT_MIN : (32'd0 - rmag[31:0]);
        end else begin
            clip_u = (rmag[47:31] != '0);
            u_next = clip_u ? epse_pkg::SAT_MAX : rmag[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            neg0_reg <= in_position[31];
            mag_reg  <= in_position[31] ? (32'd0 - in_position) : in_position;
        end
        if (ld[1]) begin
            neg1_reg <= neg0_reg;
            prod_reg <= 64'(mag_reg) * 64'(cfg.inverse_aperture);
        end
        if (ld[2]) begin
            pipe_reg.u      <= u_next;
            pipe_reg.p      <= u_next;
            pipe_reg.h_acc  <= {{(epse_pkg::ACC_W-32){cfg.base_height[31]}}, cfg.base_height};
            pipe_reg.s_acc  <= '0;
            pipe_reg.h_term <= '0;
            pipe_reg.s_term <= '0;
            // no terms means u is never formed, so no clip to report
            pipe_reg.flag   <= clip_u && (term_limit != 3'd0);
        end
    end

endmodule

// ===== hw/rtl/epse_pair.sv =====
// one power step: next power u^(n+1) and the term built on u^n
module epse_pair #(
    parameter int STEP = 1,
    parameter bit LAST = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [epse_pkg::DATA_W-1:0]   coeff,
    input  logic [2:0]                    term_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  epse_pkg::pipe_t               in_pipe,
    output logic                          out_valid,
    input  logic                          out_ready,
    output epse_pkg::pipe_t               out_pipe
);

    localparam int         K       = (STEP + 1) / 2;
    localparam int         SCALE   = 2 * K;
    localparam bit         ODD     = (STEP % 2) == 1;
    localparam logic [3:0] STEP_ID = 4'(STEP);

    logic a_valid_reg;
    logic b_valid_reg;
    logic ld_a;
    logic ld_b;

    logic [3:0] span;
    logic       term_on;

    logic signed [epse_pkg::DATA_W:0]    operand;
    logic signed [epse_pkg::PROD_W-1:0]  term_prod_next;
    logic signed [epse_pkg::PROD_W-1:0]  term_prod_reg;
    logic signed [31:0]                  a_u_reg;
    logic signed [epse_pkg::ACC_W-1:0]   a_h_reg;
    logic signed [epse_pkg::ACC_W-1:0]   a_s_reg;
    logic                                a_flag_reg;

    logic signed [epse_pkg::RND_W-1:0]   rt;
    logic signed [epse_pkg::ACC_W-1:0]   rt_ext;
    logic signed [epse_pkg::ACC_W-1:0]   h_term_next;
    logic signed [epse_pkg::ACC_W-1:0]   s_term_next;
    logic signed [31:0]                  pow_p;
    logic                                pow_clip;
    epse_pkg::pipe_t                     pipe_reg;

    assign ld_b      = !b_valid_reg || out_ready;
    assign ld_a      = !a_valid_reg || ld_b;
    assign in_ready  = ld_a;
    assign out_valid = b_valid_reg;
    assign out_pipe  = pipe_reg;

    assign span    = {term_limit, 1'b0};
    assign term_on = (span >= STEP_ID);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (ld_a) a_valid_reg <= in_valid;
            if (ld_b) b_valid_reg <= a_valid_reg;
        end
    end

    // odd steps feed the slope with u^n, even steps the height with 1 - u^n
    generate
        if (ODD) begin : g_odd_operand
            assign operand = {in_pipe.p[31], in_pipe.p};
        end else begin : g_even_operand
            assign operand = epse_pkg::ONE_Q16 - $signed({in_pipe.p[31], in_pipe.p});
        end
    endgenerate

    assign term_prod_next = $signed(coeff) * operand;

    always_ff @(posedge aclk) begin
        if (ld_a) begin
            term_prod_reg <= term_prod_next;
            a_u_reg       <= in_pipe.u;
            a_h_reg       <= in_pipe.h_acc + in_pipe.h_term;
            a_s_reg       <= in_pipe.s_acc + in_pipe.s_term;
            a_flag_reg    <= in_pipe.flag;
        end
    end

    generate
        if (!LAST) begin : g_pow
            localparam logic [3:0] NEXT_ID = 4'(STEP + 1);
            logic signed [63:0] pow_prod_reg;
            epse_pkg::sat_t     pow_sat;

            always_ff @(posedge aclk) begin
                if (ld_a) pow_prod_reg <= $signed(in_pipe.p) * $signed(in_pipe.u);
            end

            assign pow_sat  = epse_pkg::sat32(epse_pkg::rnd16({pow_prod_reg[63], pow_prod_reg}));
            assign pow_p    = pow_sat.value;
            assign pow_clip = pow_sat.clip && (span >= NEXT_ID);
        end else begin : g_no_pow
            assign pow_p    = '0;
            assign pow_clip = 1'b0;
        end
    endgenerate

    assign rt     = epse_pkg::rnd16(term_prod_reg);
    assign rt_ext = {{(epse_pkg::ACC_W-epse_pkg::RND_W){rt[epse_pkg::RND_W-1]}}, rt};

    generate
        if (ODD) begin : g_slope_term
            logic [epse_pkg::ACC_W-1:0] scaled;
            assign scaled      = rt_ext * epse_pkg::ACC_W'(SCALE);
            assign s_term_next = term_on ? $signed(scaled) : '0;
            assign h_term_next = '0;
        end else begin : g_height_term
            assign h_term_next = term_on ? rt_ext : '0;
            assign s_term_next = '0;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (ld_b) begin
            pipe_reg.u      <= a_u_reg;
            pipe_reg.p      <= pow_p;
            pipe_reg.h_acc  <= a_h_reg;
            pipe_reg.s_acc  <= a_s_reg;
            pipe_reg.h_term <= h_term_next;
            pipe_reg.s_term <= s_term_next;
            pipe_reg.flag   <= a_flag_reg | pow_clip;
        end
    end

endmodule

// ===== hw/rtl/epse_back.sv =====
// back stages: final sums, height clip, slope scaling by 1/A and clip, output register
module epse_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  epse_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  epse_pkg::pipe_t               in_pipe,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [epse_pkg::DATA_W-1:0]   out_height,
    output logic [epse_pkg::DATA_W-1:0]   out_slope,
    output logic                          out_flag
);

    localparam int ACC_W = epse_pkg::ACC_W;

    logic [4:0] v_reg;
    logic [4:0] ld;

    // stage 1
    logic signed [ACC_W-1:0] h1_reg;
    logic signed [ACC_W-1:0] s1_reg;
    logic                    f1_reg;
    // stage 2
    epse_pkg::sat_t          h_sat;
    logic [ACC_W-1:0]        m_next;
    logic [31:0]             h2_reg;
    logic [ACC_W-1:0]        m_reg;
    logic                    sneg2_reg;
    logic                    f2_reg;
    // stage 3
    logic [63:0]             t_lo_reg;
    logic [ACC_W-1:0]        t_hi_reg;
    logic [31:0]             h3_reg;
    logic                    sneg3_reg;
    logic                    f3_reg;
    // stage 4
    logic [63:0]             low_sum;
    logic [48:0]             r_wide;
    logic                    r_cap;
    logic [32:0]             r_next;
    logic [32:0]             r_reg;
    logic [31:0]             h4_reg;
    logic                    sneg4_reg;
    logic                    f4_reg;
    // stage 5
    logic                    s_clip;
    logic [31:0]             slope_next;
    logic [31:0]             height_reg;
    logic [31:0]             slope_reg;
    logic                    flag_reg;

    always_comb begin
        ld[4] = !v_reg[4] || out_ready;
        for (int i = 3; i >= 0; i--) begin
            ld[i] = !v_reg[i] || ld[i+1];
        end
    end

    assign in_ready   = ld[0];
    assign out_valid  = v_reg[4];
    assign out_height = height_reg;
    assign out_slope  = slope_reg;
    assign out_flag   = flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ld[0]) v_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++) begin
                if (ld[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign h_sat  = epse_pkg::sat32(h1_reg[epse_pkg::RND_W-1:0]);
    assign m_next = s1_reg[ACC_W-1] ? ACC_W'(-s1_reg) : s1_reg;

    // slope rescale, split into the low 32 bits and the high 22 bits of the sum magnitude
    always_comb begin
        low_sum = t_lo_reg + 64'h8000;
        r_wide  = 49'({t_hi_reg[14:0], 16'h0000}) + 49'(low_sum[63:16]);
        r_cap   = (t_hi_reg >= ACC_W'(32'h8000)) || (r_wide > 49'h1_0000_0000);
        r_next  = r_cap ? 33'h1_0000_0000 : r_wide[32:0];
    end

    // a negative sum gives a positive slope
    always_comb begin
        if (sneg4_reg) begin
            s_clip     = r_reg[32] || r_reg[31];
            slope_next = s_clip ? epse_pkg::SAT_MAX : r_reg[31:0];
        end else begin
            s_clip     = r_reg[32] || (r_reg[31] && (r_reg[30:0] != '0));
            slope_next = s_clip ? epse_pkg::SAT_MIN : (32'd0 - r_reg[31:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            h1_reg <= in_pipe.h_acc + in_pipe.h_term;
            s1_reg <= in_pipe.s_acc + in_pipe.s_term;
            f1_reg <= in_pipe.flag;
        end
        if (ld[1]) begin
            h2_reg    <= h_sat.clip ? (h1_reg[ACC_W-1] ? epse_pkg::SAT_MIN : epse_pkg::SAT_MAX)
                                    : h1_reg[31:0];
            m_reg     <= m_next;
            sneg2_reg <= s1_reg[ACC_W-1];
            f2_reg    <= f1_reg | (h1_reg[ACC_W-1:31] != {(ACC_W-31){h1_reg[31]}});
        end
        if (ld[2]) begin
            t_lo_reg  <= 64'(m_reg[31:0]) * 64'(cfg.inverse_aperture);
            t_hi_reg  <= ACC_W'(m_reg[ACC_W-1:32]) * ACC_W'(cfg.inverse_aperture);
            h3_reg    <= h2_reg;
            sneg3_reg <= sneg2_reg;
            f3_reg    <= f2_reg;
        end
        if (ld[3]) begin
            r_reg     <= r_next;
            h4_reg    <= h3_reg;
            sneg4_reg <= sneg3_reg;
            f4_reg    <= f3_reg;
        end
        if (ld[4]) begin
            height_reg <= h4_reg;
            slope_reg  <= slope_next;
            flag_reg   <= f4_reg | s_clip;
        end
    end

endmodule

// ===== hw/rtl/even_polynomial_surface_eval.sv =====
// top level of the even polynomial surface evaluator: config port and pipeline
// throughput: one request per cycle when the result channel is not stalled; the depth comes
// from the front stages and the chain of power steps, each one a multiply stage and a
// round/clip stage, then five back stages for the final sums, clips and slope rescale
// reset: synchronous active low; clears all valid bits and loads register defaults
// (height 0, 1/A = 1.0, no terms, coefficients 0)
module even_polynomial_surface_eval #(
    parameter int MAX_TERMS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // [31:0] position
    // result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [63:0]                     m_tdata,   // [31:0] height, [63:32] slope
    output logic                            m_tuser,   // [0] saturated
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [epse_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    // two pipeline steps per term: odd steps feed the slope, even ones the height
    localparam int NUM_STEPS = 2 * MAX_TERMS;

    epse_pkg::cfg_t   cfg;
    logic [2:0]       tc_eff;

    // request flow between sections, index 0 is the front output
    epse_pkg::pipe_t  pipe    [NUM_STEPS+1];
    logic             pvalid  [NUM_STEPS+1];
    logic             pready_i[NUM_STEPS+1];

    logic [31:0]      res_height;
    logic [31:0]      res_slope;
    logic             res_flag;

    epse_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // term counts beyond the built pipeline act as the full count
    assign tc_eff = (cfg.term_count > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : cfg.term_count;

    // front: u = round(x / A), clipped
    epse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .term_limit  (tc_eff),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_position (s_tdata),
        .out_valid   (pvalid[0]),
        .out_ready   (pready_i[0]),
        .out_pipe    (pipe[0])
    );

    // power chain: step n holds u^n, builds u^(n+1) and the term of u^n
    generate
        for (genvar n = 1; n <= NUM_STEPS; n++) begin : g_step
            epse_pair #(
                .STEP (n),
                .LAST (n == NUM_STEPS)
            ) u_pair (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .coeff      (cfg.coeff[(n+1)/2 - 1]),
                .term_limit (tc_eff),
                .in_valid   (pvalid[n-1]),
                .in_ready   (pready_i[n-1]),
                .in_pipe    (pipe[n-1]),
                .out_valid  (pvalid[n]),
                .out_ready  (pready_i[n]),
                .out_pipe   (pipe[n])
            );
        end
    endgenerate

    // back: last sums, clip of height, slope = -round(S / A), output register
    epse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (pvalid[NUM_STEPS]),
        .in_ready   (pready_i[NUM_STEPS]),
        .in_pipe    (pipe[NUM_STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_height (res_height),
        .out_slope  (res_slope),
        .out_flag   (res_flag)
    );

    assign m_tdata = {res_slope, res_height};
    assign m_tuser = res_flag;

`ifndef SYNTHESIS
    // an empty or draining output stage lets the whole pipeline move
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while output stage can move");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_term_count_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr[4:2] == epse_pkg::REG_TERM_COUNT))
        |=> (cfg.term_count == $past(pwdata[2:0])))
        else $error("term count write not taken");

    a_term_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        tc_eff <= 3'(MAX_TERMS))
        else $error("term limit beyond built steps");
`endif

endmodule

// ===== verif/even_polynomial_surface_eval_tb.sv =====
// self-checking testbench for the even polynomial surface evaluator (height, slope, clip flag)
module even_polynomial_surface_eval_tb;

    localparam int MAX_TERMS          = 4;
    localparam int UNMAPPED_REG_INDEX = 7;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int TAIL_CYCLES        = 60;
    localparam int IDLE_PERCENT       = 16;

    // clock and reset, all inputs known from time zero
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] position
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [31:0] height, [63:32] slope
    logic        m_tuser;         // [0] saturated
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [epse_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // one expected result per accepted request
    typedef struct {
        logic [31:0] position;
        logic [31:0] height;
        logic [31:0] slope;
        logic        saturated;
    } surface_point_t;

    surface_point_t pending_surface_q[$];

    // local copy of the register file
    longint          base_height_q  = 0;
    longint unsigned inv_aperture_q = 64'd65536;
    logic [2:0]      term_count_q   = 3'd0;
    longint          coeff_q[MAX_TERMS] = '{default: 0};

    // run bookkeeping
    int  error_count        = 0;
    int  cycle_count        = 0;
    int  positions_sent     = 0;
    int  results_checked    = 0;
    int  clipped_results    = 0;
    int  register_writes    = 0;
    int  input_stall_cycles = 0;
    bit  steady_flow        = 1'b0;

    // long receiver hold-off, asked by the test and counted by the receiver
    int  stall_ask_id  = 0;
    int  stall_ask_len = 0;
    int  stall_done_id = 0;
    int  stall_left    = 0;

    even_polynomial_surface_eval #(
        .MAX_TERMS (MAX_TERMS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // hard stop if the run hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_surface_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // fixed-point helpers for the predictor
    // ---------------------------------------------------------------------------

    // rescale by 2^16, ties away from zero
    function automatic longint round_q16(input longint v);
        bit              neg;
        longint unsigned mag;
        neg = v < 0;
        mag = neg ? -v : v;
        mag = (mag + 64'h8000) >> 16;
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

    // clip to the signed 32-bit range and note the clip
    function automatic longint clip_q16(input longint v, inout bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // height, slope and clip flag for one position under the current registers
    function automatic surface_point_t predict_surface(input logic [31:0] pos);
        surface_point_t  res;
        bit              clipped;
        bit              neg;
        bit              sneg;
        int              terms;
        int              n;
        longint          x;
        longint          height;
        longint          slope;
        longint          u;
        longint          p;
        longint          slope_sum;
        longint unsigned mag;
        longint unsigned t_lo;
        longint unsigned t_hi;
        longint unsigned r_mag;
        clipped   = 1'b0;
        terms     = (term_count_q > MAX_TERMS) ? MAX_TERMS : int'(term_count_q);
        x         = $signed(pos);
        height    = base_height_q;
        slope     = 0;
        slope_sum = 0;
        // no terms in use: u is never formed, so nothing before the output clip can flag
        if (terms > 0) begin
            neg = x < 0;
            mag = neg ? -x : x;
            mag = (mag * inv_aperture_q + 64'h8000) >> 16;
            u   = clip_q16(neg ? -$signed(mag) : $signed(mag), clipped);
            p   = u;
            // odd powers feed the slope sum, even powers the height terms
            for (n = 1; n <= 2 * terms; n++) begin
                if (n > 1)
                    p = clip_q16(round_q16(p * u), clipped);
                if (n % 2 == 1)
                    slope_sum += longint'(n + 1) * round_q16(coeff_q[(n - 1) / 2] * p);
                else
                    height += round_q16(coeff_q[n / 2 - 1] * (64'sd65536 - p));
            end
            // slope = -round(sum * 1/A), split so the product never overflows
            sneg = slope_sum < 0;
            mag  = sneg ? -slope_sum : slope_sum;
            t_lo = (mag & 64'hFFFF_FFFF) * inv_aperture_q;
            t_hi = (mag >> 32) * inv_aperture_q;
            if (t_hi >= 64'h8000)
                r_mag = 64'h1_0000_0000;
            else
                r_mag = (t_hi << 16) + ((t_lo + 64'h8000) >> 16);
            if (r_mag > 64'h1_0000_0000)
                r_mag = 64'h1_0000_0000;
            slope = sneg ? $signed(r_mag) : -$signed(r_mag);
        end
        height        = clip_q16(height, clipped);
        slope         = clip_q16(slope, clipped);
        res.position  = pos;
        res.height    = 32'(height);
        res.slope     = 32'(slope);
        res.saturated = clipped;
        return res;
    endfunction

    // ---------------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 30)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    // apb write: setup cycle, access cycle, then back to idle
    task automatic write_register(input int unsigned index, input logic [31:0] value);
        logic [epse_pkg::ADDR_W-1:0] addr;
        addr = {index[epse_pkg::ADDR_W-3:0], 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        register_writes++;
        case (index)
            epse_pkg::REG_BASE_HEIGHT:      base_height_q  = $signed(value);
            epse_pkg::REG_INVERSE_APERTURE: inv_aperture_q = value;
            epse_pkg::REG_TERM_COUNT:       term_count_q   = value[2:0];
            epse_pkg::REG_COEFF_ONE, epse_pkg::REG_COEFF_TWO,
            epse_pkg::REG_COEFF_THREE, epse_pkg::REG_COEFF_FOUR:
                coeff_q[index - epse_pkg::REG_COEFF_ONE] = $signed(value);
            default: ;   // unmapped index, the block ignores it
        endcase
        @(posedge aclk);
    endtask

    // offer one position, holding valid until the block takes it
    task automatic send_position(input logic [31:0] pos);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pos;
        @(posedge aclk);
        while (!s_tready) begin
            input_stall_cycles++;
            @(posedge aclk);
        end
        pending_surface_q = {pending_surface_q, predict_surface(pos)};
        positions_sent++;
    endtask

    // drop valid and wait until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_surface_q.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] small_signed(input int unsigned lim);
        return 32'(longint'($urandom_range(2 * lim)) - longint'(lim));
    endfunction

    // mostly positions within about 1.25 apertures, the rest anywhere
    function automatic logic [31:0] pick_position();
        longint      reach;
        int unsigned off;
        if ($urandom_range(99) < 20 || inv_aperture_q == 0)
            return $urandom;
        reach = (64'sd5 << 30) / inv_aperture_q;
        if (reach > 64'sd2147483647)
            reach = 64'sd2147483647;
        off = $urandom_range(32'(2 * reach));
        return 32'(longint'(off) - reach);
    endfunction

    // wild settings use the full register range, tame ones a plausible lens
    task automatic randomize_surface_config(input bit wild);
        int k;
        write_register(epse_pkg::REG_BASE_HEIGHT, wild ? $urandom : small_signed(32'd6553600));
        write_register(epse_pkg::REG_INVERSE_APERTURE,
                       wild ? $urandom : $urandom_range(262144, 4096));
        write_register(epse_pkg::REG_TERM_COUNT,
                       wild ? (($urandom & 32'hFFFF_FFF8) | $urandom_range(7))
                            : $urandom_range(7));
        for (k = 0; k < MAX_TERMS; k++)
            write_register(epse_pkg::REG_COEFF_ONE + k,
                           wild ? $urandom : small_signed(32'd524288));
    endtask

    // ---------------------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------------------

    // reset values and the no-terms path, plus a write to an unmapped index
    task automatic test_no_terms();
        send_position(32'h0000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        wait_drained();
        write_register(epse_pkg::REG_BASE_HEIGHT, 32'h7FFF_FFFF);
        write_register(UNMAPPED_REG_INDEX, 32'h0000_0004);
        send_position(32'h1234_5678);
        send_position(32'hFFFF_0000);
        wait_drained();
    endtask

    // field extremes, excess term count, clipping everywhere, zero reciprocal aperture
    task automatic test_directed_extremes();
        logic [31:0] unit_points[9] = '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000,
                                        32'h0000_8000, 32'hFFFE_8000, 32'h7FFF_FFFF,
                                        32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF};
        write_register(epse_pkg::REG_BASE_HEIGHT, 32'h0001_0000);
        write_register(epse_pkg::REG_INVERSE_APERTURE, 32'h0001_0000);
        write_register(epse_pkg::REG_COEFF_ONE, 32'h0001_0000);
        write_register(epse_pkg::REG_COEFF_TWO, 32'hFFFF_8000);
        write_register(epse_pkg::REG_COEFF_THREE, 32'h0000_4000);
        write_register(epse_pkg::REG_COEFF_FOUR, 32'h0002_0000);
        write_register(epse_pkg::REG_TERM_COUNT, 32'd4);
        foreach (unit_points[i])
            send_position(unit_points[i]);
        wait_drained();
        // term count above the term limit acts as the limit
        write_register(epse_pkg::REG_TERM_COUNT, 32'd7);
        send_position(32'h0001_0000);
        send_position(32'hFFFF_8000);
        wait_drained();
        // only the low three bits of the term count matter
        write_register(epse_pkg::REG_TERM_COUNT, 32'hFFFF_FFF9);
        send_position(32'h0001_0000);
        wait_drained();
        // everything at full scale: u, powers, height and slope all clip
        write_register(epse_pkg::REG_TERM_COUNT, 32'd4);
        write_register(epse_pkg::REG_INVERSE_APERTURE, 32'hFFFF_FFFF);
        write_register(epse_pkg::REG_BASE_HEIGHT, 32'h8000_0000);
        write_register(epse_pkg::REG_COEFF_ONE, 32'h7FFF_FFFF);
        write_register(epse_pkg::REG_COEFF_TWO, 32'h8000_0000);
        write_register(epse_pkg::REG_COEFF_THREE, 32'h7FFF_FFFF);
        write_register(epse_pkg::REG_COEFF_FOUR, 32'h8000_0000);
        send_position(32'h7FFF_FFFF);
        send_position(32'h8000_0000);
        send_position(32'h0000_0001);
        send_position(32'h0000_0000);
        wait_drained();
        // zero reciprocal aperture collapses u to zero
        write_register(epse_pkg::REG_INVERSE_APERTURE, 32'h0000_0000);
        send_position(32'h7FFF_FFFF);
        wait_drained();
    endtask

    // several register settings, random positions under each
    task automatic test_random_settings();
        int phase;
        int i;
        for (phase = 0; phase < 6; phase++) begin
            randomize_surface_config(phase % 3 == 2);
            for (i = 0; i < 80; i++)
                send_position(pick_position());
            wait_drained();
        end
    endtask

    // receiver holds off long enough for the block to fill and push back
    task automatic test_backpressure();
        int i;
        randomize_surface_config(1'b0);
        write_register(epse_pkg::REG_TERM_COUNT, 32'd4);
        steady_flow   = 1'b1;
        stall_ask_len = 400;
        stall_ask_id++;
        for (i = 0; i < 120; i++)
            send_position(pick_position());
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // no idling on either side
    task automatic test_steady_stream();
        int i;
        randomize_surface_config(1'b0);
        steady_flow = 1'b1;
        for (i = 0; i < 100; i++)
            send_position(pick_position());
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // ---------------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------------

    // receiver: long hold-off first, then steady or random readiness
    always @(posedge aclk) begin
        if (stall_ask_id != stall_done_id) begin
            stall_done_id <= stall_ask_id;
            stall_left    <= stall_ask_len;
            m_tready      <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (steady_flow) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // compare every accepted result with the oldest prediction
    always @(posedge aclk) begin
        surface_point_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_surface_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: height %h slope %h",
                                          m_tdata[31:0], m_tdata[63:32]));
            end else begin
                want = pending_surface_q.pop_front();
                results_checked++;
                if (m_tuser)
                    clipped_results++;
                if (m_tdata[31:0] !== want.height)
                    report_mismatch($sformatf("x %h height %h want %h", want.position,
                                              m_tdata[31:0], want.height));
                if (m_tdata[63:32] !== want.slope)
                    report_mismatch($sformatf("x %h slope %h want %h", want.position,
                                              m_tdata[63:32], want.slope));
                if (m_tuser !== want.saturated)
                    report_mismatch($sformatf("x %h saturated %b want %b", want.position,
                                              m_tuser, want.saturated));
            end
        end
    end

    // ---------------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------------

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_no_terms();
        test_directed_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        // let anything stray come out before judging
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_surface_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_surface_q.size()));

        $display("checked %0d results from %0d positions over %0d register writes",
                 results_checked, positions_sent, register_writes);
        $display("%0d results clipped, input held back for %0d cycles",
                 clipped_results, input_stall_cycles);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", error_count);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
